// ===== hw/rtl/flac_pkg.sv =====
// Package with the widths, register indexes and shared types of the anomaly classifier.
package flac_pkg;

   localparam int EventW      = 10;
   localparam int WeightW     = 16;
   localparam int MaxWeights  = 16;
   localparam int WeightIdxW  = 4;
   localparam int WordW       = 64;
   localparam int NumWords    = 4;
   localparam int BiasW       = 24;
   localparam int BiasTermW   = 32;
   localparam int ProdW       = 27;
   localparam int AccW        = 40;
   localparam int ScoreW      = 41;
   localparam int CountW      = 32;
   localparam int CsrIndexW   = 3;

   localparam int SeqLengthDefault  = 100;
   localparam int NumWeightsDefault = 16;

   // The natural log of 1.5 in Q.12, scaled by one million.
   localparam longint unsigned Ln1p5Q12Micro = 64'd1660785083;

   localparam logic [CsrIndexW-1:0] CSR_WEIGHT_WORD_0 = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_WEIGHT_WORD_1 = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_WEIGHT_WORD_2 = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_WEIGHT_WORD_3 = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_BIAS_Q12      = 3'd4;

   typedef logic [MaxWeights-1:0][WeightW-1:0] flac_weights_type;
   typedef logic [NumWords-1:0][WordW-1:0] flac_words_type;

   typedef struct packed {
      logic                    valid;
      logic                    last;
      logic                    label;
      logic signed [ProdW-1:0] prod;
   } flac_stage_type;

endpackage

// ===== hw/rtl/flac_front.sv =====
// Front stage: sequence position, weight select, multiply and the input register.
module flac_front #(
   parameter int SEQUENCE_LENGTH = flac_pkg::SeqLengthDefault,
   parameter int NUM_WEIGHTS     = flac_pkg::NumWeightsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [flac_pkg::EventW-1:0]    req_event_value,
   input  logic                           req_true_label,
   input  logic                           req_last_element,
   input  flac_pkg::flac_weights_type     weights,
   input  logic                           stage_ready,
   output flac_pkg::flac_stage_type       stage
);
   import flac_pkg::*;

   localparam int PosW = $clog2(SEQUENCE_LENGTH + 1);
   localparam int BinW = $clog2(NUM_WEIGHTS);

   logic [PosW-1:0]          position_ff;
   logic [PosW-1:0]          position_in;
   logic [BinW-1:0]          bin_ff;
   logic [BinW-1:0]          bin_in;
   flac_stage_type           stage_ff;
   flac_stage_type           stage_in;
   logic                     accept;
   logic                     in_range;
   logic signed [WeightW-1:0] weight;
   logic signed [ProdW-1:0]  product;

   assign req_stall = stage_ff.valid && !stage_ready;
   assign accept    = req_valid && !req_stall;
   assign in_range  = position_ff < PosW'(SEQUENCE_LENGTH);
   assign weight    = $signed(weights[WeightIdxW'(bin_ff)]);
   assign product   = ProdW'($signed({1'b0, req_event_value}) * weight);

   always_comb begin
      position_in = position_ff;
      bin_in      = bin_ff;
      stage_in    = stage_ff;
      if (accept) begin
         if (req_last_element) begin
            position_in = '0;
            bin_in      = '0;
         end else if (in_range) begin
            position_in = position_ff + 1'b1;
            bin_in      = (bin_ff == BinW'(NUM_WEIGHTS - 1)) ? '0 : bin_ff + 1'b1;
         end
         stage_in.valid = 1'b1;
         stage_in.last  = req_last_element;
         stage_in.label = req_true_label;
         stage_in.prod  = in_range ? product : '0;
      end else if (stage_ready) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         bin_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         position_ff <= position_in;
         bin_ff      <= bin_in;
         stage_ff    <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

// ===== hw/rtl/flac_score.sv =====
// Score stage: accumulator, threshold compare, confusion counters and the result register.
module flac_score (
   input  logic                                 clock,
   input  logic                                 reset,
   input  flac_pkg::flac_stage_type             stage,
   output logic                                 stage_ready,
   input  logic signed [flac_pkg::ScoreW-1:0]   thr_adj,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_anomaly_flag,
   output logic [flac_pkg::CountW-1:0]          rsp_true_pos_count,
   output logic [flac_pkg::CountW-1:0]          rsp_false_pos_count,
   output logic [flac_pkg::CountW-1:0]          rsp_true_neg_count,
   output logic [flac_pkg::CountW-1:0]          rsp_false_neg_count
);
   import flac_pkg::*;

   logic signed [AccW-1:0]   acc_ff;
   logic signed [AccW-1:0]   acc_in;
   logic signed [AccW-1:0]   acc_sum;
   logic [CountW-1:0]        tp_ff, tp_in;
   logic [CountW-1:0]        fp_ff, fp_in;
   logic [CountW-1:0]        tn_ff, tn_in;
   logic [CountW-1:0]        fn_ff, fn_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     flag_ff, flag_in;
   logic                     consume;
   logic                     pred;

   assign stage_ready = !stage.last || !rsp_valid_ff || !rsp_stall;
   assign consume     = stage.valid && stage_ready;
   assign acc_sum     = acc_ff + {{(AccW - ProdW){stage.prod[ProdW-1]}}, stage.prod};
   assign pred        = $signed({acc_sum[AccW-1], acc_sum}) > thr_adj;

   always_comb begin
      acc_in       = acc_ff;
      tp_in        = tp_ff;
      fp_in        = fp_ff;
      tn_in        = tn_ff;
      fn_in        = fn_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (consume) begin
         if (stage.last) begin
            acc_in       = '0;
            flag_in      = pred;
            rsp_valid_in = 1'b1;
            priority if (pred && stage.label) begin
               tp_in = (tp_ff == '1) ? tp_ff : tp_ff + 1'b1;
            end else if (pred) begin
               fp_in = (fp_ff == '1) ? fp_ff : fp_ff + 1'b1;
            end else if (!stage.label) begin
               tn_in = (tn_ff == '1) ? tn_ff : tn_ff + 1'b1;
            end else begin
               fn_in = (fn_ff == '1) ? fn_ff : fn_ff + 1'b1;
            end
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         tp_ff        <= '0;
         fp_ff        <= '0;
         tn_ff        <= '0;
         fn_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         tp_ff        <= tp_in;
         fp_ff        <= fp_in;
         tn_ff        <= tn_in;
         fn_ff        <= fn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flag_ff <= flag_in;
   end

   // The counters change only when a new result is loaded, so they serve as its payload.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_anomaly_flag    = flag_ff;
   assign rsp_true_pos_count  = tp_ff;
   assign rsp_false_pos_count = fp_ff;
   assign rsp_true_neg_count  = tn_ff;
   assign rsp_false_neg_count = fn_ff;

endmodule

// ===== hw/rtl/folded_linear_anomaly_classifier.sv =====
// Top level of the folded linear anomaly classifier with its control registers.
//
//   Channel | Ports   | Direction | Transfer
//   input   | req_*   | in        | req_valid high and req_stall low at a rising edge
//   result  | rsp_*   | out       | rsp_valid high and rsp_stall low at a rising edge
//   control | csr_*   | in        | csr_write high at a rising edge
//
// One item is accepted per cycle while req_stall is low; a last item passes the front register and the result register.
// The rate is set by the single multiply of the front stage and the accumulator add.
// A last item waits in the front register only while an earlier result is stalled.
// Synchronous reset clears the weights, bias, sequence position, accumulator, valids and counters.
module folded_linear_anomaly_classifier #(
   parameter int SEQUENCE_LENGTH = flac_pkg::SeqLengthDefault,
   parameter int NUM_WEIGHTS     = flac_pkg::NumWeightsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [flac_pkg::EventW-1:0]      req_event_value,
   input  logic                             req_true_label,
   input  logic                             req_last_element,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_anomaly_flag,
   output logic [flac_pkg::CountW-1:0]      rsp_true_pos_count,
   output logic [flac_pkg::CountW-1:0]      rsp_false_pos_count,
   output logic [flac_pkg::CountW-1:0]      rsp_true_neg_count,
   output logic [flac_pkg::CountW-1:0]      rsp_false_neg_count,
   input  logic                             csr_write,
   input  logic [flac_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [flac_pkg::WordW-1:0]       csr_data
);
   import flac_pkg::*;

   localparam longint unsigned ThrU =
      (64'(SEQUENCE_LENGTH) * Ln1p5Q12Micro) / 64'd1000000;
   localparam logic signed [ScoreW-1:0] ThrS = ScoreW'(ThrU);
   localparam logic signed [BiasTermW-1:0] SeqLenS = BiasTermW'(SEQUENCE_LENGTH);

   flac_words_type              weight_word_ff, weight_word_in;
   logic [BiasW-1:0]            bias_ff, bias_in;
   logic signed [ScoreW-1:0]    thr_adj_ff, thr_adj_in;
   logic signed [BiasTermW-1:0] bias_term;
   flac_weights_type            weights;
   flac_stage_type              stage;
   logic                        stage_ready;

   always_comb begin
      weight_word_in = weight_word_ff;
      bias_in        = bias_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_WEIGHT_WORD_0: weight_word_in[0] = csr_data;
            CSR_WEIGHT_WORD_1: weight_word_in[1] = csr_data;
            CSR_WEIGHT_WORD_2: weight_word_in[2] = csr_data;
            CSR_WEIGHT_WORD_3: weight_word_in[3] = csr_data;
            CSR_BIAS_Q12:      bias_in = csr_data[BiasW-1:0];
            default: begin
            end
         endcase
      end
   end

   // The score test compares the accumulator with the threshold less the scaled bias.
   assign bias_term  = SeqLenS * $signed({{(BiasTermW - BiasW){bias_ff[BiasW-1]}}, bias_ff});
   assign thr_adj_in = ThrS - {{(ScoreW - BiasTermW){bias_term[BiasTermW-1]}}, bias_term};

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_word_ff <= '0;
         bias_ff        <= '0;
         thr_adj_ff     <= ThrS;
      end else begin
         weight_word_ff <= weight_word_in;
         bias_ff        <= bias_in;
         thr_adj_ff     <= thr_adj_in;
      end
   end

   assign weights = flac_weights_type'(weight_word_ff);

   flac_front #(
      .SEQUENCE_LENGTH (SEQUENCE_LENGTH),
      .NUM_WEIGHTS     (NUM_WEIGHTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_event_value  (req_event_value),
      .req_true_label   (req_true_label),
      .req_last_element (req_last_element),
      .weights          (weights),
      .stage_ready      (stage_ready),
      .stage            (stage)
   );

   flac_score u_score (
      .clock               (clock),
      .reset               (reset),
      .stage               (stage),
      .stage_ready         (stage_ready),
      .thr_adj             (thr_adj_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_anomaly_flag    (rsp_anomaly_flag),
      .rsp_true_pos_count  (rsp_true_pos_count),
      .rsp_false_pos_count (rsp_false_pos_count),
      .rsp_true_neg_count  (rsp_true_neg_count),
      .rsp_false_neg_count (rsp_false_neg_count)
   );

endmodule

// ===== hw/rtl/flac_checker.sv =====
// Port-level checker for the anomaly classifier and its bind to the top level.
module flac_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_anomaly_flag,
   input logic [flac_pkg::CountW-1:0]   rsp_true_pos_count,
   input logic [flac_pkg::CountW-1:0]   rsp_false_pos_count,
   input logic [flac_pkg::CountW-1:0]   rsp_true_neg_count,
   input logic [flac_pkg::CountW-1:0]   rsp_false_neg_count
);
   import flac_pkg::*;

   // A stalled result keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_anomaly_flag)
         && $stable(rsp_true_pos_count) && $stable(rsp_false_pos_count)
         && $stable(rsp_true_neg_count) && $stable(rsp_false_neg_count))
      else $error("stalled result changed");

   // No result is shown in the cycle after reset.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The counters never decrease outside reset.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_true_pos_count >= $past(rsp_true_pos_count)
         && rsp_false_pos_count >= $past(rsp_false_pos_count)
         && rsp_true_neg_count >= $past(rsp_true_neg_count)
         && rsp_false_neg_count >= $past(rsp_false_neg_count))
      else $error("confusion counter decreased");

   // Each sequence moves at most one counter.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> $countones({rsp_true_pos_count != $past(rsp_true_pos_count),
         rsp_false_pos_count != $past(rsp_false_pos_count),
         rsp_true_neg_count != $past(rsp_true_neg_count),
         rsp_false_neg_count != $past(rsp_false_neg_count)}) <= 1)
      else $error("more than one counter changed");

   // A counter moves only together with a valid result.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (rsp_true_pos_count != $past(rsp_true_pos_count)
         || rsp_false_pos_count != $past(rsp_false_pos_count)
         || rsp_true_neg_count != $past(rsp_true_neg_count)
         || rsp_false_neg_count != $past(rsp_false_neg_count)) |-> rsp_valid)
      else $error("counter changed without a result");

endmodule

bind folded_linear_anomaly_classifier flac_checker u_flac_checker (.*);
